// ===== rtl/core/stl_pkg.sv =====
// shared types and constants for the sorted timer list engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    localparam int REQ_W    = 3;
    localparam int ID_W     = 4;
    localparam int EXP_W    = 32;
    localparam int STATUS_W = 3;
    localparam int EVENT_W  = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEL   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MOD   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DRAIN = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LISTED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_LISTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTHING    = 3'd4;

    // result event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_FIRED   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_QUEUED  = 2'd2;
    localparam logic [EVENT_W-1:0] EV_DRAINED = 2'd3;

    // a drain request reports at most this many entries
    localparam int MAX_RESULTS = 16;
    localparam int DRAIN_CNT_W = $clog2(MAX_RESULTS);

    // cell operations, broadcast to the whole row
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;
    localparam logic [1:0] CELL_POP    = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  slot;
        logic [EXP_W-1:0] expiry;
    } cell_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [ID_W-1:0]  slot;
        logic [EXP_W-1:0] expiry;
    } cell_cmd_t;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] slot;
    } fifo_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
    } fifo_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     fired_id;
        logic [EVENT_W-1:0]  event_res;
        logic                last;
    } result_t;

    localparam cell_t CELL_EMPTY = '{valid: 1'b0, slot: '0, expiry: '0};

endpackage

`default_nettype wire

// ===== rtl/core/stl_cell.sv =====
// one cell of the sorted timer row: holds one slot and its expiry
// depends on stl_pkg
`timescale 1ns / 1ps
`default_nettype none

module stl_cell
    import stl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  cell_t     left_data,
    input  logic      left_lt,
    input  cell_t     right_data,
    input  logic      hit_in,
    output cell_t     data,
    output logic      lt,
    output logic      hit_out
);

    logic             valid_reg;
    logic [ID_W-1:0]  slot_reg;
    logic [EXP_W-1:0] expiry_reg;
    cell_t            cell_next;

    assign data    = '{valid: valid_reg, slot: slot_reg, expiry: expiry_reg};
    // strict compare puts a new timer ahead of equal expiries
    assign lt      = valid_reg && (expiry_reg < cmd.expiry);
    assign hit_out = hit_in || (valid_reg && (slot_reg == cmd.slot));

    always_comb
    begin
        cell_next = data;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (!lt)
                begin
                    cell_next = left_lt
                        ? '{valid: 1'b1, slot: cmd.slot, expiry: cmd.expiry}
                        : left_data;
                end
            end
            CELL_REMOVE:
            begin
                if (hit_out)
                begin
                    cell_next = right_data;
                end
            end
            CELL_POP:
            begin
                cell_next = right_data;
            end
            default:
            begin
                cell_next = data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= cell_next.slot;
        expiry_reg <= cell_next.expiry;
    end

endmodule

`default_nettype wire

// ===== rtl/core/stl_fifo.sv =====
// deferred timer fifo: circular buffer in a memory with registered read
// depends on stl_pkg
`timescale 1ns / 1ps
`default_nettype none

module stl_fifo
    import stl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  fifo_ctl_t       ctl,
    output fifo_stat_t      stat,
    output logic [ID_W-1:0] rd_slot
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_W-1:0]  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  rd_data_reg;

    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.one_left = (count_reg == CNT_W'(1));
    assign rd_slot       = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= ctl.slot;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_timer_list_engine.sv =====
// Sorted timer list engine. Timers live in a row of NUM_TIMERS cells kept in
// expiry order (a new timer goes ahead of equal expiries); each cell compares
// itself against the broadcast key and takes its own value, the new entry or a
// neighbor's, so add, delete and head pop each act on the whole row at once.
// Requests arrive on the s_axis side and every request gives one or more
// results on the m_axis side, the final one marked by tlast. A modify first
// removes the entry, then re-inserts it; a tick pops each due head in turn;
// a drain reads each entry from the deferred fifo memory, which has a
// registered read port, before reporting it. A stalled result side holds
// the flow back since the single output register must be free before each
// result is made.
// The next request is taken while the last result still waits. Ticks pop only
// a head whose expiry equals the new count; a head already past its expiry
// blocks the list. A drain reports at most 16 entries, the rest stay queued.
// No clearing pass is needed after reset.
// depends on stl_pkg, stl_cell and stl_fifo
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_list_engine
    import stl_pkg::*;
#(
    parameter int NUM_TIMERS  = 16,
    parameter int DEFER_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // timer_id[3:0], expiry[35:4], defer[36], zero pad
    input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[2:0], fired_id[6:3], event_res[8:7],
                                        // tick_now[40:9], zero pad
    output logic        m_axis_tlast
);

    localparam int          IDX_W        = $clog2(NUM_TIMERS);
    localparam logic [31:0] NUM_TIMERS_U = 32'(NUM_TIMERS);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_MOD_INS   = 3'd2;
    localparam logic [2:0] S_TICK      = 3'd3;
    localparam logic [2:0] S_DRAIN_RD  = 3'd4;
    localparam logic [2:0] S_DRAIN_OUT = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [REQ_W-1:0]       req_type_reg;
    logic [ID_W-1:0]        req_id_reg;
    logic [EXP_W-1:0]       req_exp_reg;
    logic                   req_defer_reg;
    logic [EXP_W-1:0]       tick_count_reg, tick_count_next;
    logic [NUM_TIMERS-1:0]  listed_reg, listed_next;
    logic [NUM_TIMERS-1:0]  defer_reg, defer_next;
    logic [DRAIN_CNT_W-1:0] drain_cnt_reg, drain_cnt_next;
    logic                   out_valid_reg;
    result_t                out_res_reg;
    logic [EXP_W-1:0]       out_tick_reg;

    cell_cmd_t              cmd;
    cell_t                  cells [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  lt_vec;
    logic [NUM_TIMERS:0]    hit_chain;
    logic [NUM_TIMERS-1:0]  valid_vec;
    logic [NUM_TIMERS-2:0]  order_ok;

    fifo_ctl_t              fifo_ctl;
    fifo_stat_t             fifo_stat;
    logic [ID_W-1:0]        fifo_rd_slot;

    logic                   req_accept;
    logic                   out_free;
    logic                   emit;
    result_t                res;
    logic                   id_in_range;
    logic [IDX_W-1:0]       req_idx;
    logic [IDX_W-1:0]       head_idx;
    logic                   head_match;
    logic                   next_match;
    logic                   list_full;

    // handshake and port packing
    assign s_axis_tready = (state_reg == S_IDLE);
    assign req_accept    = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {7'b0, out_tick_reg, out_res_reg.event_res,
                            out_res_reg.fired_id, out_res_reg.status};

    // request decode helpers
    assign id_in_range = (32'(req_id_reg) < NUM_TIMERS_U);
    assign req_idx     = IDX_W'(req_id_reg);
    assign head_idx    = IDX_W'(cells[0].slot);
    assign head_match  = cells[0].valid && (cells[0].expiry == tick_count_reg);
    assign next_match  = cells[1].valid && (cells[1].expiry == tick_count_reg);
    assign list_full   = cells[NUM_TIMERS-1].valid;

    // row of cells; the hit chain marks every cell at or after a removed entry
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        cell_t left_data;
        logic  left_lt;
        cell_t right_data;

        if (i == 0)
        begin : g_first
            assign left_data = CELL_EMPTY;
            assign left_lt   = 1'b1;
        end
        else
        begin : g_mid
            assign left_data = cells[i-1];
            assign left_lt   = lt_vec[i-1];
        end

        if (i == NUM_TIMERS - 1)
        begin : g_last
            assign right_data = CELL_EMPTY;
        end
        else
        begin : g_inner
            assign right_data = cells[i+1];
        end

        stl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_data  (left_data),
            .left_lt    (left_lt),
            .right_data (right_data),
            .hit_in     (hit_chain[i]),
            .data       (cells[i]),
            .lt         (lt_vec[i]),
            .hit_out    (hit_chain[i+1])
        );

        assign valid_vec[i] = cells[i].valid;
    end

    // list invariant: valid entries packed at the front, expiries non-decreasing
    for (genvar i = 0; i < NUM_TIMERS - 1; i++)
    begin : g_order
        assign order_ok[i] = !cells[i+1].valid ||
                             (cells[i].valid && (cells[i].expiry <= cells[i+1].expiry));
    end

    stl_fifo #(
        .DEPTH (DEFER_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fifo_ctl),
        .stat    (fifo_stat),
        .rd_slot (fifo_rd_slot)
    );

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        listed_next     = listed_reg;
        defer_next      = defer_reg;
        drain_cnt_next  = drain_cnt_reg;
        cmd             = '{op: CELL_HOLD, slot: req_id_reg, expiry: req_exp_reg};
        fifo_ctl        = '{push: 1'b0, pop: 1'b0, slot: cells[0].slot};
        emit            = 1'b0;
        res             = '{status: ST_NOTHING, fired_id: '0, event_res: EV_NONE,
                            last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (req_type_reg == REQ_TICK)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                    state_next      = S_TICK;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    unique case (req_type_reg) inside
                        REQ_ADD, REQ_DEL, REQ_MOD:
                        begin
                            res.fired_id = req_id_reg;
                            if (!id_in_range)
                            begin
                                res.status = ST_NOTHING;
                            end
                            else if (req_type_reg == REQ_ADD)
                            begin
                                if (listed_reg[req_idx])
                                begin
                                    res.status = ST_LISTED;
                                end
                                else
                                begin
                                    res.status          = ST_OK;
                                    defer_next[req_idx] = req_defer_reg;
                                    if (!list_full)
                                    begin
                                        cmd.op               = CELL_INSERT;
                                        listed_next[req_idx] = 1'b1;
                                    end
                                end
                            end
                            else if (!listed_reg[req_idx])
                            begin
                                res.status = ST_NOT_LISTED;
                            end
                            else
                            begin
                                res.status = ST_OK;
                                cmd.op     = CELL_REMOVE;
                                if (req_type_reg == REQ_DEL)
                                begin
                                    listed_next[req_idx] = 1'b0;
                                end
                                else
                                begin
                                    // modify keeps the listed and defer flags
                                    state_next = S_MOD_INS;
                                end
                            end
                        end
                        REQ_DRAIN:
                        begin
                            if (!fifo_stat.empty)
                            begin
                                emit           = 1'b0;
                                drain_cnt_next = '0;
                                state_next     = S_DRAIN_RD;
                            end
                        end
                        default:
                        begin
                            res.status = ST_NOTHING;
                        end
                    endcase
                end
            end

            S_MOD_INS:
            begin
                cmd.op     = CELL_INSERT;
                state_next = S_IDLE;
            end

            S_TICK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (head_match)
                    begin
                        cmd.op                = CELL_POP;
                        listed_next[head_idx] = 1'b0;
                        res.fired_id          = cells[0].slot;
                        res.last              = !next_match;
                        if (defer_reg[head_idx])
                        begin
                            if (!fifo_stat.full)
                            begin
                                fifo_ctl.push = 1'b1;
                                res.status    = ST_OK;
                                res.event_res = EV_QUEUED;
                            end
                            else
                            begin
                                // fifo full: the entry is dropped
                                res.status    = ST_OVERFLOW;
                                res.event_res = EV_NONE;
                            end
                        end
                        else
                        begin
                            res.status    = ST_OK;
                            res.event_res = EV_FIRED;
                        end
                        if (!next_match)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        // no head due: report nothing
                        state_next = S_IDLE;
                    end
                end
            end

            S_DRAIN_RD:
            begin
                state_next = S_DRAIN_OUT;
            end

            S_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    fifo_ctl.pop   = 1'b1;
                    res.status     = ST_OK;
                    res.event_res  = EV_DRAINED;
                    res.fired_id   = fifo_rd_slot;
                    res.last       = fifo_stat.one_left ||
                                     (drain_cnt_reg == DRAIN_CNT_W'(MAX_RESULTS - 1));
                    drain_cnt_next = drain_cnt_reg + 1'b1;
                    state_next     = res.last ? S_IDLE : S_DRAIN_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            listed_reg     <= '0;
            defer_reg      <= '0;
            drain_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            listed_reg     <= listed_next;
            defer_reg      <= defer_next;
            drain_cnt_reg  <= drain_cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_type_reg  <= s_axis_tuser;
            req_id_reg    <= s_axis_tdata[3:0];
            req_exp_reg   <= s_axis_tdata[35:4];
            req_defer_reg <= s_axis_tdata[36];
        end
        if (emit)
        begin
            out_res_reg  <= res;
            out_tick_reg <= tick_count_reg;
        end
    end

    // the row stays sorted and packed at the front
    a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &order_ok)
        else $error("timer row out of order or not packed");

    // listed flags track the row, except between remove and re-insert of a modify
    a_listed_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_MOD_INS) |-> ($countones(listed_reg) == $countones(valid_vec)))
        else $error("listed flags disagree with row contents");

    // a result is only made when the output register can take it
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwrote a waiting result");

    // the deferred fifo is never pushed while full
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctl.push |-> !fifo_stat.full)
        else $error("push into full deferred fifo");

endmodule

`default_nettype wire
